@@ hdl/fls_pkg.sv @@
// Package for the filling line sequencer: line state codes, drive bit
// positions and the structs that pass between the sequencer modules.
// Depends on nothing.
`default_nettype none

package fls_pkg;

	// Line state codes as seen on the line_state port.
	typedef enum logic [3:0] {
		ST_CONFIG      = 4'd0,
		ST_IDLE        = 4'd1,
		ST_READY       = 4'd2,
		ST_CONVEYOR    = 4'd3,
		ST_CHECK_DOSER = 4'd4,
		ST_CYLINDER    = 4'd5,
		ST_MOVE_OUT    = 4'd6,
		ST_DONE        = 4'd7,
		ST_TIMEOUT     = 4'd8,
		ST_EMERGENCY   = 4'd9,
		ST_RES_LOW     = 4'd10,
		ST_FAULT       = 4'd11
	} line_state_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_CONTAINER_COUNT = 2'd0;
	localparam logic [1:0] REG_TEMP_THRESHOLD  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_LIMIT   = 2'd2;

	// Bit positions in the drive vector.
	localparam int DRV_DOSER    = 0;
	localparam int DRV_CONVEYOR = 1;
	localparam int DRV_CYLINDER = 2;
	localparam int DRV_RED      = 3;
	localparam int DRV_YELLOW   = 4;

	localparam logic [6:0] MAX_CONTAINERS = 7'd99;
	localparam logic [7:0] TIMEOUT_SAT    = 8'd255;

	// Reset values of the configuration registers.
	localparam logic [6:0] CONTAINER_COUNT_RST = 7'd0;
	localparam logic [9:0] TEMP_THRESHOLD_RST  = 10'd717;
	localparam logic [7:0] TIMEOUT_LIMIT_RST   = 8'd15;

	typedef struct packed {
		logic [6:0] container_count;
		logic [9:0] temperature_threshold;
		logic [7:0] timeout_limit;
	} cfg_t;

	typedef struct packed {
		logic       emergency_event;
		logic       start_switch;
		logic       reservoir_low;
		logic       container_in_place;
		logic       doser_full;
		logic       doser_has_product;
		logic       reset_button;
		logic       emergency_button;
		logic [9:0] temperature_sample;
		logic       timer_tick;
	} poll_t;

	typedef struct packed {
		line_state_t line_state;
		logic [6:0]  remaining;
		logic [7:0]  timeout_count;
		logic        batch_done;
		logic [4:0]  drive;
	} seq_state_t;

endpackage

`default_nettype wire

@@ hdl/fls_cfg.sv @@
// Configuration registers of the filling line sequencer.
// Depends on fls_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module fls_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_write,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [9:0]    cfg_data,
	output fls_pkg::cfg_t      cfg
);

	fls_pkg::cfg_t cfg_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.container_count       <= fls_pkg::CONTAINER_COUNT_RST;
			cfg_q.temperature_threshold <= fls_pkg::TEMP_THRESHOLD_RST;
			cfg_q.timeout_limit         <= fls_pkg::TIMEOUT_LIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				fls_pkg::REG_CONTAINER_COUNT: cfg_q.container_count <= cfg_data[6:0];
				fls_pkg::REG_TEMP_THRESHOLD:  cfg_q.temperature_threshold <= cfg_data;
				fls_pkg::REG_TIMEOUT_LIMIT:   cfg_q.timeout_limit <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hdl/fls_step.sv @@
// Next-state logic of the filling line sequencer: one poll applied to the
// current line state. Depends on fls_pkg for state codes and structs.
`default_nettype none

module fls_step (
	input  wire fls_pkg::seq_state_t cur,
	input  wire fls_pkg::poll_t      poll,
	input  wire fls_pkg::cfg_t       cfg,
	output fls_pkg::seq_state_t      nxt
);

	logic [4:0] motion;
	logic       timed_out;

	assign motion = (5'd1 << fls_pkg::DRV_DOSER) | (5'd1 << fls_pkg::DRV_CONVEYOR)
		| (5'd1 << fls_pkg::DRV_CYLINDER);

	always_comb begin
		nxt = cur;

		// The tick counts only while the conveyor was already running.
		if (poll.timer_tick && cur.drive[fls_pkg::DRV_CONVEYOR]
				&& (cur.timeout_count != fls_pkg::TIMEOUT_SAT)) begin
			nxt.timeout_count = cur.timeout_count + 8'd1;
		end
		timed_out = nxt.timeout_count > cfg.timeout_limit;

		// An emergency event forces the emergency state before the step.
		if (poll.emergency_event) begin
			nxt.line_state = fls_pkg::ST_EMERGENCY;
			nxt.drive = nxt.drive & ~motion;
			nxt.drive[fls_pkg::DRV_RED] = 1'b1;
		end

		// One step of the line sequence.
		case (nxt.line_state)
			fls_pkg::ST_IDLE: begin
				if (poll.start_switch) nxt.line_state = fls_pkg::ST_READY;
			end
			fls_pkg::ST_READY: begin
				if (poll.reservoir_low) begin
					nxt.line_state = fls_pkg::ST_RES_LOW;
				end else if (poll.temperature_sample > cfg.temperature_threshold) begin
					nxt.line_state = fls_pkg::ST_CONVEYOR;
					nxt.drive[fls_pkg::DRV_CONVEYOR] = 1'b1;
					nxt.timeout_count = 8'd0;
				end
			end
			fls_pkg::ST_CONVEYOR: begin
				if (poll.reservoir_low) begin
					nxt.line_state = fls_pkg::ST_RES_LOW;
					nxt.drive[fls_pkg::DRV_DOSER] = 1'b0;
					nxt.drive[fls_pkg::DRV_CONVEYOR] = 1'b0;
				end else if (poll.container_in_place) begin
					nxt.line_state = fls_pkg::ST_CHECK_DOSER;
					nxt.drive[fls_pkg::DRV_CONVEYOR] = 1'b0;
				end else if (nxt.remaining == 7'd0) begin
					nxt.line_state = fls_pkg::ST_DONE;
					nxt.batch_done = 1'b1;
					nxt.drive = nxt.drive & ~motion;
				end else if (timed_out) begin
					nxt.line_state = fls_pkg::ST_TIMEOUT;
					nxt.drive = nxt.drive & ~motion;
					nxt.drive[fls_pkg::DRV_RED] = 1'b1;
				end
			end
			fls_pkg::ST_CHECK_DOSER: begin
				if (poll.doser_full && !poll.doser_has_product) begin
					nxt.line_state = fls_pkg::ST_FAULT;
					nxt.drive = nxt.drive & ~motion;
					nxt.drive[fls_pkg::DRV_RED] = 1'b1;
				end else if (poll.doser_full && poll.doser_has_product) begin
					nxt.drive[fls_pkg::DRV_DOSER] = 1'b0;
					nxt.drive[fls_pkg::DRV_CYLINDER] = 1'b1;
					nxt.line_state = fls_pkg::ST_CYLINDER;
				end else if (!poll.doser_has_product) begin
					nxt.drive[fls_pkg::DRV_DOSER] = 1'b1;
				end
			end
			fls_pkg::ST_CYLINDER: begin
				if (!poll.doser_has_product) begin
					nxt.drive[fls_pkg::DRV_CYLINDER] = 1'b0;
					nxt.line_state = fls_pkg::ST_MOVE_OUT;
					nxt.drive[fls_pkg::DRV_CONVEYOR] = 1'b1;
					nxt.timeout_count = 8'd0;
				end
			end
			fls_pkg::ST_MOVE_OUT: begin
				if (!poll.container_in_place) begin
					nxt.line_state = fls_pkg::ST_CONVEYOR;
					if (nxt.remaining != 7'd0) nxt.remaining = nxt.remaining - 7'd1;
				end else if (timed_out) begin
					nxt.line_state = fls_pkg::ST_TIMEOUT;
					nxt.drive = nxt.drive & ~motion;
					nxt.drive[fls_pkg::DRV_RED] = 1'b1;
				end
			end
			fls_pkg::ST_DONE: begin
				nxt.drive[fls_pkg::DRV_YELLOW] = nxt.batch_done;
				if (poll.reset_button) begin
					nxt.line_state = fls_pkg::ST_CONFIG;
					nxt.drive[fls_pkg::DRV_YELLOW] = 1'b0;
				end
			end
			fls_pkg::ST_TIMEOUT, fls_pkg::ST_FAULT: begin
				if (poll.reset_button) begin
					nxt.line_state = fls_pkg::ST_CONFIG;
					nxt.drive[fls_pkg::DRV_RED] = 1'b0;
				end
			end
			fls_pkg::ST_EMERGENCY: begin
				if (!poll.emergency_button) begin
					nxt.drive[fls_pkg::DRV_RED] = 1'b0;
					nxt.line_state = fls_pkg::ST_CONFIG;
				end
			end
			fls_pkg::ST_RES_LOW: begin
				nxt.drive[fls_pkg::DRV_RED] = 1'b0;
				if (!poll.reservoir_low) nxt.line_state = fls_pkg::ST_CONFIG;
			end
			default: begin
				// Configure, or any unknown code: load a new batch once the last one is used up.
				if (nxt.remaining == 7'd0) begin
					nxt.remaining = (cfg.container_count > fls_pkg::MAX_CONTAINERS)
						? fls_pkg::MAX_CONTAINERS : cfg.container_count;
				end
				nxt.line_state = fls_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/filling_line_sequencer.sv @@
// Top level of the filling line sequencer: poll register, line state,
// result register and handshakes. Depends on fls_pkg, fls_cfg and fls_step.
//
//   channel | direction | handshake             | payload
//   poll    | in        | in_valid / in_ready   | ten sensor and event fields
//   result  | out       | out_valid / out_ready | state, count, five drives
//   config  | in        | cfg_write             | cfg_index, cfg_data
//
// A poll is taken into the poll register; once the result register is free,
// the step logic updates the line state and loads the result register from
// it. One poll is taken per cycle while the result channel is not stalled.
// A stalled result holds the result register; the poll register then fills,
// and in_ready falls until the result is taken.
// Reset puts the line in configure with everything off and the configuration
// registers at their reset values.
`default_nettype none

module filling_line_sequencer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic       emergency_event,
	input  wire logic       start_switch,
	input  wire logic       reservoir_low,
	input  wire logic       container_in_place,
	input  wire logic       doser_full,
	input  wire logic       doser_has_product,
	input  wire logic       reset_button,
	input  wire logic       emergency_button,
	input  wire logic [9:0] temperature_sample,
	input  wire logic       timer_tick,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [3:0] line_state,
	output      logic [6:0] remaining_count,
	output      logic       doser_motor,
	output      logic       conveyor_motor,
	output      logic       cylinder_drive,
	output      logic       red_lamp,
	output      logic       yellow_lamp,
	input  wire logic       cfg_write,
	input  wire logic [1:0] cfg_index,
	input  wire logic [9:0] cfg_data
);

	fls_pkg::cfg_t       cfg;
	fls_pkg::poll_t      poll_s1;
	logic                valid_s1;
	fls_pkg::seq_state_t state_q;
	fls_pkg::seq_state_t state_nxt;
	logic                valid_s2;
	logic [3:0]          line_state_s2;
	logic [6:0]          remaining_s2;
	logic [4:0]          drive_s2;
	logic                advance;

	fls_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fls_step u_step (
		.cur  (state_q),
		.poll (poll_s1),
		.cfg  (cfg),
		.nxt  (state_nxt)
	);

	// The poll stage moves on whenever the result register is free.
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Poll register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			poll_s1 <= '{emergency_event, start_switch, reservoir_low,
				container_in_place, doser_full, doser_has_product, reset_button,
				emergency_button, temperature_sample, timer_tick};
		end
	end

	// Line state, updated once for every poll that leaves the poll stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.line_state    <= fls_pkg::ST_CONFIG;
			state_q.remaining     <= 7'd0;
			state_q.timeout_count <= 8'd0;
			state_q.batch_done    <= 1'b0;
			state_q.drive         <= 5'd0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			line_state_s2 <= state_nxt.line_state;
			remaining_s2  <= state_nxt.remaining;
			drive_s2      <= state_nxt.drive;
		end
	end

	assign out_valid       = valid_s2;
	assign line_state      = line_state_s2;
	assign remaining_count = remaining_s2;
	assign doser_motor     = drive_s2[fls_pkg::DRV_DOSER];
	assign conveyor_motor  = drive_s2[fls_pkg::DRV_CONVEYOR];
	assign cylinder_drive  = drive_s2[fls_pkg::DRV_CYLINDER];
	assign red_lamp        = drive_s2[fls_pkg::DRV_RED];
	assign yellow_lamp     = drive_s2[fls_pkg::DRV_YELLOW];

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for filling_line_sequencer: sensor polls go in by
// handshake, an in-order predictor of the line sequencer checks every result.
// Depends on fls_pkg and the filling_line_sequencer RTL.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;

	// One result transaction as seen on the output channel.
	typedef struct packed {
		logic [3:0] line_state;
		logic [6:0] remaining;
		logic       doser;
		logic       conveyor;
		logic       cylinder;
		logic       red;
		logic       yellow;
	} line_result_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	fls_pkg::poll_t poll_bus = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	logic [3:0]     line_state;
	logic [6:0]     remaining_count;
	logic           doser_motor;
	logic           conveyor_motor;
	logic           cylinder_drive;
	logic           red_lamp;
	logic           yellow_lamp;
	logic           cfg_write = 1'b0;
	logic [1:0]     cfg_index = '0;
	logic [9:0]     cfg_data = '0;

	// Predicted line state and configuration.
	fls_pkg::line_state_t line_now;
	logic [6:0]  to_fill;
	logic [7:0]  conveyor_ticks;
	logic        batch_flag;
	logic [4:0]  drives;
	logic [6:0]  cfg_containers;
	logic [9:0]  cfg_threshold;
	logic [7:0]  cfg_tick_limit;

	line_result_t predicted_line_outputs[$];
	int          mismatch_count = 0;
	int          result_count = 0;
	int          cycle_count;
	bit          idling = 1'b0;
	int          hold_off_cycles = 0;

	always #5 clk = ~clk;

	filling_line_sequencer i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.emergency_event    (poll_bus.emergency_event),
		.start_switch       (poll_bus.start_switch),
		.reservoir_low      (poll_bus.reservoir_low),
		.container_in_place (poll_bus.container_in_place),
		.doser_full         (poll_bus.doser_full),
		.doser_has_product  (poll_bus.doser_has_product),
		.reset_button       (poll_bus.reset_button),
		.emergency_button   (poll_bus.emergency_button),
		.temperature_sample (poll_bus.temperature_sample),
		.timer_tick         (poll_bus.timer_tick),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.line_state         (line_state),
		.remaining_count    (remaining_count),
		.doser_motor        (doser_motor),
		.conveyor_motor     (conveyor_motor),
		.cylinder_drive     (cylinder_drive),
		.red_lamp           (red_lamp),
		.yellow_lamp        (yellow_lamp),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	// Drive helpers of the predictor.
	function automatic void stop_motion();
		drives[fls_pkg::DRV_DOSER] = 1'b0;
		drives[fls_pkg::DRV_CONVEYOR] = 1'b0;
		drives[fls_pkg::DRV_CYLINDER] = 1'b0;
	endfunction

	function automatic void raise_alarm();
		stop_motion();
		drives[fls_pkg::DRV_RED] = 1'b1;
	endfunction

	function automatic void run_conveyor();
		drives[fls_pkg::DRV_CONVEYOR] = 1'b1;
		conveyor_ticks = '0;
	endfunction

	// Advances the predicted line by one poll and returns the expected outputs.
	function automatic line_result_t advance_line(input fls_pkg::poll_t p);
		line_result_t r;
		if (p.timer_tick && drives[fls_pkg::DRV_CONVEYOR]
				&& conveyor_ticks != fls_pkg::TIMEOUT_SAT)
			conveyor_ticks = conveyor_ticks + 8'd1;
		if (p.emergency_event) begin
			line_now = fls_pkg::ST_EMERGENCY;
			raise_alarm();
		end
		case (line_now)
			fls_pkg::ST_IDLE: begin
				if (p.start_switch)
					line_now = fls_pkg::ST_READY;
			end
			fls_pkg::ST_READY: begin
				if (p.reservoir_low) begin
					line_now = fls_pkg::ST_RES_LOW;
				end else if (p.temperature_sample > cfg_threshold) begin
					line_now = fls_pkg::ST_CONVEYOR;
					run_conveyor();
				end
			end
			fls_pkg::ST_CONVEYOR: begin
				if (p.reservoir_low) begin
					line_now = fls_pkg::ST_RES_LOW;
					drives[fls_pkg::DRV_DOSER] = 1'b0;
					drives[fls_pkg::DRV_CONVEYOR] = 1'b0;
				end else if (p.container_in_place) begin
					line_now = fls_pkg::ST_CHECK_DOSER;
					drives[fls_pkg::DRV_CONVEYOR] = 1'b0;
				end else if (to_fill == '0) begin
					line_now = fls_pkg::ST_DONE;
					batch_flag = 1'b1;
					stop_motion();
				end else if (conveyor_ticks > cfg_tick_limit) begin
					line_now = fls_pkg::ST_TIMEOUT;
					raise_alarm();
				end
			end
			fls_pkg::ST_CHECK_DOSER: begin
				if (p.doser_full && !p.doser_has_product) begin
					line_now = fls_pkg::ST_FAULT;
					raise_alarm();
				end else if (p.doser_full && p.doser_has_product) begin
					drives[fls_pkg::DRV_DOSER] = 1'b0;
					drives[fls_pkg::DRV_CYLINDER] = 1'b1;
					line_now = fls_pkg::ST_CYLINDER;
				end else if (!p.doser_has_product) begin
					drives[fls_pkg::DRV_DOSER] = 1'b1;
				end
			end
			fls_pkg::ST_CYLINDER: begin
				if (!p.doser_has_product) begin
					drives[fls_pkg::DRV_CYLINDER] = 1'b0;
					line_now = fls_pkg::ST_MOVE_OUT;
					run_conveyor();
				end
			end
			fls_pkg::ST_MOVE_OUT: begin
				if (!p.container_in_place) begin
					line_now = fls_pkg::ST_CONVEYOR;
					if (to_fill != '0)
						to_fill = to_fill - 7'd1;
				end else if (conveyor_ticks > cfg_tick_limit) begin
					line_now = fls_pkg::ST_TIMEOUT;
					raise_alarm();
				end
			end
			fls_pkg::ST_DONE: begin
				drives[fls_pkg::DRV_YELLOW] = batch_flag;
				if (p.reset_button) begin
					line_now = fls_pkg::ST_CONFIG;
					drives[fls_pkg::DRV_YELLOW] = 1'b0;
				end
			end
			fls_pkg::ST_TIMEOUT, fls_pkg::ST_FAULT: begin
				if (p.reset_button) begin
					line_now = fls_pkg::ST_CONFIG;
					drives[fls_pkg::DRV_RED] = 1'b0;
				end
			end
			fls_pkg::ST_EMERGENCY: begin
				if (!p.emergency_button) begin
					drives[fls_pkg::DRV_RED] = 1'b0;
					line_now = fls_pkg::ST_CONFIG;
				end
			end
			fls_pkg::ST_RES_LOW: begin
				drives[fls_pkg::DRV_RED] = 1'b0;
				if (!p.reservoir_low)
					line_now = fls_pkg::ST_CONFIG;
			end
			default: begin
				// Configure, or any unknown code: load a new batch if the last one ran out.
				if (to_fill == '0)
					to_fill = (cfg_containers > fls_pkg::MAX_CONTAINERS)
						? fls_pkg::MAX_CONTAINERS : cfg_containers;
				line_now = fls_pkg::ST_IDLE;
			end
		endcase
		r.line_state = line_now;
		r.remaining = to_fill;
		r.doser = drives[fls_pkg::DRV_DOSER];
		r.conveyor = drives[fls_pkg::DRV_CONVEYOR];
		r.cylinder = drives[fls_pkg::DRV_CYLINDER];
		r.red = drives[fls_pkg::DRV_RED];
		r.yellow = drives[fls_pkg::DRV_YELLOW];
		return r;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idling || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// A random poll, mostly shaped so that the line moves on from its present state.
	function automatic fls_pkg::poll_t guided_poll();
		fls_pkg::poll_t p;
		int r;
		p = fls_pkg::poll_t'(19'($urandom));
		r = $urandom_range(0, 19);
		if ($urandom_range(0, 99) < 85) begin
			p.emergency_event = ($urandom_range(0, 99) < 1);
			p.reservoir_low = ($urandom_range(0, 99) < 1);
			case (line_now)
				fls_pkg::ST_IDLE: p.start_switch = ($urandom_range(0, 9) < 7);
				fls_pkg::ST_READY: begin
					if (cfg_threshold != 10'h3FF && $urandom_range(0, 9) < 7)
						p.temperature_sample =
							10'($urandom_range(int'(cfg_threshold) + 1, 1023));
				end
				fls_pkg::ST_CONVEYOR: begin
					p.container_in_place = ($urandom_range(0, 99) < 35);
					p.timer_tick = ($urandom_range(0, 99) < 70);
				end
				fls_pkg::ST_MOVE_OUT: begin
					p.container_in_place = ($urandom_range(0, 99) < 50);
					p.timer_tick = ($urandom_range(0, 99) < 70);
				end
				fls_pkg::ST_CHECK_DOSER: begin
					// Occasional sensor fault, otherwise dosing runs until full.
					p.doser_full = (r == 0 || r >= 12);
					p.doser_has_product = (r >= 8);
				end
				fls_pkg::ST_CYLINDER: p.doser_has_product = ($urandom_range(0, 1) == 1);
				fls_pkg::ST_DONE, fls_pkg::ST_TIMEOUT, fls_pkg::ST_FAULT:
					p.reset_button = ($urandom_range(0, 9) < 4);
				fls_pkg::ST_EMERGENCY: p.emergency_button = ($urandom_range(0, 1) == 1);
				fls_pkg::ST_RES_LOW: p.reservoir_low = ($urandom_range(0, 1) == 1);
				default: ;
			endcase
		end
		return p;
	endfunction

	// Offers one poll transaction and records its prediction once it is taken.
	task automatic send_poll(input fls_pkg::poll_t p);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		poll_bus = p;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predicted_line_outputs.push_back(advance_line(p));
	endtask

	// Stops offering polls and waits until every predicted result has come.
	task automatic drain_line();
		@(negedge clk);
		in_valid = 1'b0;
		wait (predicted_line_outputs.size() == 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			fls_pkg::REG_CONTAINER_COUNT: cfg_containers = value[6:0];
			fls_pkg::REG_TEMP_THRESHOLD:  cfg_threshold = value;
			fls_pkg::REG_TIMEOUT_LIMIT:   cfg_tick_limit = value[7:0];
			default: ;
		endcase
	endtask

	// Writes all three registers once no result is outstanding; unused upper bits are random.
	task automatic set_config(input logic [6:0] count, input logic [9:0] threshold,
			input logic [7:0] limit);
		drain_line();
		write_reg(fls_pkg::REG_CONTAINER_COUNT, {3'($urandom), count});
		write_reg(fls_pkg::REG_TEMP_THRESHOLD, threshold);
		write_reg(fls_pkg::REG_TIMEOUT_LIMIT, {2'($urandom), limit});
	endtask

	task automatic run_guided(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 120 == 0)
				idling = ($urandom_range(0, 3) != 0);
			send_poll(guided_poll());
		end
	endtask

	// One full batch with the reset configuration: a zero count, the threshold
	// edge, a doser that is neither full nor empty, and the count held at zero.
	task automatic test_first_batch();
		fls_pkg::poll_t p;
		p = '0;
		send_poll(p);
		p.start_switch = 1'b1;
		send_poll(p);
		p = '0;
		p.temperature_sample = 10'd717;
		send_poll(p);
		p.temperature_sample = 10'd718;
		send_poll(p);
		p = '0;
		p.container_in_place = 1'b1;
		p.timer_tick = 1'b1;
		send_poll(p);
		p.timer_tick = 1'b0;
		p.doser_has_product = 1'b1;
		send_poll(p);
		p.doser_has_product = 1'b0;
		send_poll(p);
		p.doser_full = 1'b1;
		p.doser_has_product = 1'b1;
		send_poll(p);
		p = '0;
		p.container_in_place = 1'b1;
		send_poll(p);
		p = '0;
		send_poll(p);
		send_poll(p);
		send_poll(p);
		p.reset_button = 1'b1;
		send_poll(p);
	endtask

	// An out-of-range count loads as the maximum; an emergency stop then clears.
	task automatic test_emergency_stop();
		fls_pkg::poll_t p;
		drain_line();
		write_reg(fls_pkg::REG_CONTAINER_COUNT, 10'd127);
		p = '0;
		send_poll(p);
		p.emergency_event = 1'b1;
		p.emergency_button = 1'b1;
		send_poll(p);
		p = '0;
		send_poll(p);
	endtask

	task automatic test_reservoir_low();
		fls_pkg::poll_t p;
		p = '0;
		send_poll(p);
		p.start_switch = 1'b1;
		send_poll(p);
		p = '0;
		p.reservoir_low = 1'b1;
		send_poll(p);
		send_poll(p);
		p = '0;
		send_poll(p);
	endtask

	task automatic test_conveyor_timeout();
		fls_pkg::poll_t p;
		drain_line();
		write_reg(fls_pkg::REG_TIMEOUT_LIMIT, 10'd0);
		p = '0;
		send_poll(p);
		p.start_switch = 1'b1;
		send_poll(p);
		p = '0;
		p.temperature_sample = 10'h3FF;
		send_poll(p);
		p = '0;
		p.timer_tick = 1'b1;
		send_poll(p);
		p = '0;
		p.reset_button = 1'b1;
		send_poll(p);
	endtask

	// The receiver holds off while polls keep coming, so the input stalls.
	task automatic test_backpressure();
		idling = 1'b0;
		hold_off_cycles = 60;
		run_guided(40);
		drain_line();
	endtask

	task automatic test_random_batches();
		set_config(7'd3, 10'd717, 8'd15);
		run_guided(300);
		set_config(7'd0, 10'd0, 8'd0);
		run_guided(250);
		set_config(7'd127, 10'h3FF, 8'd255);
		run_guided(100);
		set_config(7'd1, 10'd512, 8'd2);
		run_guided(300);
		set_config(7'd99, 10'd100, 8'd255);
		run_guided(200);
		set_config(7'd5, 10'd300, 8'd7);
		run_guided(250);
	endtask

	// With the largest limit the tick count saturates and never times out.
	task automatic test_tick_saturation();
		fls_pkg::poll_t p;
		int i;
		set_config(7'd99, 10'd0, 8'd255);
		i = 0;
		while (!(line_now == fls_pkg::ST_CONVEYOR && to_fill != '0) && i < 400) begin
			send_poll(guided_poll());
			i++;
		end
		for (i = 0; i < 280; i++) begin
			p = fls_pkg::poll_t'(19'($urandom));
			p.emergency_event = 1'b0;
			p.reservoir_low = 1'b0;
			p.container_in_place = 1'b0;
			p.timer_tick = 1'b1;
			send_poll(p);
		end
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("result %0d: %s expected %0d, got %0d", result_count, name, want, got);
		end
	endtask

	// Each result transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		line_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_line_outputs.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result %0d arrived with no poll waiting for it", result_count);
			end else begin
				want = predicted_line_outputs.pop_front();
				compare_field("line_state", want.line_state, line_state);
				compare_field("remaining_count", want.remaining, remaining_count);
				compare_field("doser_motor", want.doser, doser_motor);
				compare_field("conveyor_motor", want.conveyor, conveyor_motor);
				compare_field("cylinder_drive", want.cylinder, cylinder_drive);
				compare_field("red_lamp", want.red, red_lamp);
				compare_field("yellow_lamp", want.yellow, yellow_lamp);
			end
			result_count++;
		end
	end

	// Receiver: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				out_ready = 1'b0;
				repeat (hold_off_cycles) @(negedge clk);
				hold_off_cycles = 0;
			end
			gap = pick_gap();
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			repeat ($urandom_range(0, 8)) @(negedge clk);
		end
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// Reset, then the tests in turn.
	initial begin
		line_now = fls_pkg::ST_CONFIG;
		to_fill = '0;
		conveyor_ticks = '0;
		batch_flag = 1'b0;
		drives = '0;
		cfg_containers = fls_pkg::CONTAINER_COUNT_RST;
		cfg_threshold = fls_pkg::TEMP_THRESHOLD_RST;
		cfg_tick_limit = fls_pkg::TIMEOUT_LIMIT_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_first_batch();
		test_emergency_stop();
		test_reservoir_low();
		test_conveyor_timeout();
		idling = 1'b1;
		test_backpressure();
		test_random_batches();
		test_tick_saturation();

		drain_line();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
hdl/fls_pkg.sv
hdl/fls_cfg.sv
hdl/fls_step.sv
hdl/filling_line_sequencer.sv
tb/testbench.sv
